// ===== sv/kfct_pkg.sv =====
// Shared types and constants for the keyboard character tracker.
`timescale 1ns / 1ps

package kfct_pkg;

    localparam int KEY_W   = 10;
    localparam int CHAR_W  = 16;
    localparam int PRESS_W = 8;
    localparam int ANY_W   = 16;

    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;
    localparam logic [ANY_W-1:0]   ANY_MAX   = '1;

    typedef enum logic [2:0] {
        KIND_DOWN     = 3'd0,
        KIND_UP       = 3'd1,
        KIND_POP      = 3'd2,
        KIND_FLUSH    = 3'd3,
        KIND_MPRESS   = 3'd4,
        KIND_MRELEASE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  key_code;
        logic [CHAR_W-1:0] char_code;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        logic [CHAR_W-1:0] last_char;
        logic [ANY_W-1:0]  any_key_count;
        logic              mouse_down;
    } out_t;

endpackage

// ===== sv/keyboard_char_fifo_tracker.sv =====
// Top level: keyboard event tracker with type-ahead character ring.
`timescale 1ns / 1ps

// Channel   Signals                        Direction  Payload
// input     in_valid / in_ready / in_data  in         in_t  (kind, key_code, char_code)
// output    out_valid / out_ready / out_data  out     out_t (one result per item)
//
// Each item is read from the press count and ring memories when it is taken,
// then computed and written back in ST_EXEC. Reset and flush each start a sweep
// over all MAX_KEY+1 entries of the press count memory; no transfer is taken in
// then, and in_ready rises once the state returns to ST_IDLE after the sweep.
// A result sits in an output register, so the next item may be taken while it
// waits; an item stalls in ST_EXEC only if that register is still full.

module keyboard_char_fifo_tracker #(
    parameter int MAX_KEY    = 511,
    parameter int FIFO_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  kfct_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output kfct_pkg::out_t out_data
);
    import kfct_pkg::*;

    localparam int SLOT_W = $clog2(MAX_KEY + 1);
    localparam int PTR_W  = $clog2(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [CHAR_W-1:0] char_store [FIFO_DEPTH];

    state_t             state_reg, state_next;
    in_t                item_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CHAR_W-1:0]  ch_rd_reg;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CHAR_W-1:0]  latest_reg, latest_next;
    logic [ANY_W-1:0]   any_reg, any_next;
    logic               held_reg, held_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic               accept;
    logic               slot_free;
    logic               exec_fire;
    logic [SLOT_W-1:0]  in_slot;
    logic [PRESS_W-1:0] cnt_rd;
    logic               cnt_busy;
    logic               cnt_clear;
    logic               cnt_wr_en;
    logic [PRESS_W-1:0] cnt_wr_data;
    logic               ch_wr_en;
    logic [PTR_W-1:0]   wp_inc;
    logic [CHAR_W-1:0]  pop_char;
    logic               pop_valid;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign exec_fire = (state_reg == ST_EXEC) && slot_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign wp_inc    = ring_next(wp_reg);

    // out-of-range codes share slot MAX_KEY with key code MAX_KEY
    assign in_slot = (in_data.key_code > KEY_W'(MAX_KEY)) ? SLOT_W'(MAX_KEY)
                                                         : in_data.key_code[SLOT_W-1:0];

    kfct_press_mem #(
        .MAX_KEY (MAX_KEY)
    ) u_press_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (cnt_clear),
        .busy        (cnt_busy),
        .rd_en       (accept),
        .rd_slot     (in_slot),
        .rd_data     (cnt_rd),
        .wr_en       (cnt_wr_en),
        .wr_slot     (slot_reg),
        .wr_data     (cnt_wr_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        latest_next    = latest_reg;
        any_next       = any_reg;
        held_next      = held_reg;
        cnt_clear      = 1'b0;
        cnt_wr_en      = 1'b0;
        cnt_wr_data    = cnt_rd;
        ch_wr_en       = 1'b0;
        pop_char       = '0;
        pop_valid      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (!cnt_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    case (item_reg.kind)
                        KIND_DOWN:
                        begin
                            if (item_reg.char_code != '0)
                            begin
                                cnt_wr_en = 1'b1;
                                if (cnt_rd != PRESS_MAX)
                                begin
                                    cnt_wr_data = cnt_rd + 1'b1;
                                end
                                if (wp_inc != rp_reg)
                                begin
                                    ch_wr_en    = 1'b1;
                                    wp_next     = wp_inc;
                                    latest_next = item_reg.char_code;
                                    if (any_reg != ANY_MAX)
                                    begin
                                        any_next = any_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        KIND_UP:
                        begin
                            if (cnt_rd == '0)
                            begin
                                any_next = '0;
                            end
                            else
                            begin
                                cnt_wr_en   = 1'b1;
                                cnt_wr_data = cnt_rd - 1'b1;
                                if (any_reg != '0)
                                begin
                                    any_next = any_reg - 1'b1;
                                end
                            end
                        end
                        KIND_POP:
                        begin
                            if (rp_reg != wp_reg)
                            begin
                                pop_char  = ch_rd_reg;
                                pop_valid = 1'b1;
                                rp_next   = ring_next(rp_reg);
                            end
                        end
                        KIND_FLUSH:
                        begin
                            rp_next     = '0;
                            wp_next     = '0;
                            latest_next = '0;
                            any_next    = '0;
                            cnt_clear   = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        KIND_MPRESS:
                        begin
                            held_next = 1'b1;
                        end
                        KIND_MRELEASE:
                        begin
                            held_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next         = 1'b1;
                    out_next.char_out      = pop_char;
                    out_next.char_valid    = pop_valid;
                    out_next.last_char     = latest_next;
                    out_next.any_key_count = any_next;
                    out_next.mouse_down    = held_next;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rp_reg        <= '0;
            wp_reg        <= '0;
            latest_reg    <= '0;
            any_reg       <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            latest_reg    <= latest_next;
            any_reg       <= any_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg <= in_data;
            slot_reg <= in_slot;
        end
    end

    // ring store: read at the head when an item is taken, written on enqueue
    always_ff @(posedge clk)
    begin
        if (ch_wr_en)
        begin
            char_store[wp_reg] <= item_reg.char_code;
        end
        if (accept)
        begin
            ch_rd_reg <= char_store[rp_reg];
        end
    end

endmodule

// ===== sv/kfct_press_mem.sv =====
// Per-key press count memory with a clearing sweep after reset and flush.
`timescale 1ns / 1ps

module kfct_press_mem #(
    parameter int MAX_KEY = 511,
    localparam int SLOT_W = $clog2(MAX_KEY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear_start,
    output logic                         busy,
    input  logic                         rd_en,
    input  logic [SLOT_W-1:0]            rd_slot,
    output logic [kfct_pkg::PRESS_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [SLOT_W-1:0]            wr_slot,
    input  logic [kfct_pkg::PRESS_W-1:0] wr_data
);
    import kfct_pkg::*;

    localparam int DEPTH = MAX_KEY + 1;

    logic [PRESS_W-1:0] mem [DEPTH];
    logic               clr_active_reg;
    logic               clr_active_next;
    logic [SLOT_W-1:0]  clr_idx_reg;
    logic [SLOT_W-1:0]  clr_idx_next;
    logic [PRESS_W-1:0] rd_data_reg;
    logic               clr_last;

    assign clr_last = (clr_idx_reg == SLOT_W'(MAX_KEY));
    assign busy     = clr_active_reg;
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clear_start)
        begin
            clr_active_next = 1'b1;
            clr_idx_next    = '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_last)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // sweep owns the write port while active
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

endmodule
